// ===== rtl/lavm_pkg.sv =====
`default_nettype none
package lavm_pkg;

    // one signed fixed-point matrix word
    typedef logic signed [31:0] word_t;

    // index of a four-word group on the output
    typedef logic [1:0] grp_t;

    localparam grp_t GRP_X = 2'd0;
    localparam grp_t GRP_Y = 2'd1;
    localparam grp_t GRP_Z = 2'd2;
    localparam grp_t GRP_T = 2'd3;

    // saturation limits
    localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
    localparam word_t WORD_MIN = 32'sh8000_0000;

    // the largest magnitude is scaled so its leading one sits on this bit
    localparam int NORM_MSB = 29;

endpackage
`default_nettype wire

// ===== rtl/look_at_view_matrix.sv =====
//  channel   direction  handshake                 payload
//  in        in         in_valid / in_stall       eye_*, target_*, up_* (Q16.16 by default)
//  out       out        out_valid / out_stall     group_index, word_a..word_d, last_group,
//                                                 degenerate
//
//  one request enters the pipeline per cycle while nothing waits at the end; each request
//  leaves as four groups, and the four-group output buffer sets the sustained rate: it
//  takes the next request only as the last group of the one before is taken.
//  rst_n clears only the valid bits and the group counter; no clearing pass.
//  the whole pipeline freezes once its last stage holds a result the buffer cannot take
//  (buffer still sending or out_stall high); in_stall is high exactly then.
`default_nettype none
module look_at_view_matrix #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire lavm_pkg::word_t        eye_x,
    input  wire lavm_pkg::word_t        eye_y,
    input  wire lavm_pkg::word_t        eye_z,
    input  wire lavm_pkg::word_t        target_x,
    input  wire lavm_pkg::word_t        target_y,
    input  wire lavm_pkg::word_t        target_z,
    input  wire lavm_pkg::word_t        up_x,
    input  wire lavm_pkg::word_t        up_y,
    input  wire lavm_pkg::word_t        up_z,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output lavm_pkg::grp_t              group_index,
    output lavm_pkg::word_t             word_a,
    output lavm_pkg::word_t             word_b,
    output lavm_pkg::word_t             word_c,
    output lavm_pkg::word_t             word_d,
    output logic                        last_group,
    output logic                        degenerate
);

    localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);
    localparam lavm_pkg::word_t ONE = lavm_pkg::word_t'(32'd1 << FRAC_BITS);

    typedef struct packed {
        lavm_pkg::word_t ux, uy, uz;
        lavm_pkg::word_t vx, vy, vz;
        lavm_pkg::word_t nx, ny, nz;
        lavm_pkg::word_t ex, ey, ez;
        lavm_pkg::word_t tu, tv, tn;
        logic            ok;
    } mat_t;

    // negate if asked, then magnitude plus half an lsb, with its sign
    function automatic logic [64:0] rnd_lo(input logic signed [63:0] x, input logic neg);
        logic signed [63:0] y;
        logic [63:0]        mg;
        logic               s;
        y  = neg ? -x : x;
        s  = y[63];
        mg = s ? (~unsigned'(y) + 64'd1) : unsigned'(y);
        return {s, mg + HALF};
    endfunction

    // drop the fraction, restore sign, saturate
    function automatic lavm_pkg::word_t rnd_hi(input logic [64:0] sm);
        logic [63:0] mm;
        mm = sm[63:0] >> FRAC_BITS;
        if (!sm[64])
        begin
            return (mm > 64'h7FFF_FFFF) ? lavm_pkg::WORD_MAX : lavm_pkg::word_t'(mm[31:0]);
        end
        return (mm > 64'h8000_0000) ? lavm_pkg::WORD_MIN
                                    : lavm_pkg::word_t'(~mm[31:0] + 32'd1);
    endfunction

    logic en;
    logic load;
    logic out_take;

    // view direction, eye minus target
    logic signed [32:0] d [3];
    logic [191:0]       side1;

    always_comb
    begin
        d[0] = {eye_x[31], eye_x} - {target_x[31], target_x};
        d[1] = {eye_y[31], eye_y} - {target_y[31], target_y};
        d[2] = {eye_z[31], eye_z} - {target_z[31], target_z};
    end

    assign side1 = {eye_x, eye_y, eye_z, up_x, up_y, up_z};

    logic            n1_valid;
    lavm_pkg::word_t n1 [3];
    logic            n1_ok;
    logic [191:0]    n1_side;

    lavm_norm #(
        .IW        (33),
        .SW        (192),
        .FRAC_BITS (FRAC_BITS)
    ) u_norm_n (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_c      (d),
        .in_side   (side1),
        .out_valid (n1_valid),
        .out_n     (n1),
        .out_ok    (n1_ok),
        .out_side  (n1_side)
    );

    // up cross n: products
    lavm_pkg::word_t    ue [3];
    logic signed [63:0] xp_reg [6];
    lavm_pkg::word_t    xe_reg [3];
    lavm_pkg::word_t    xn_reg [3];
    logic               xok_reg;

    always_comb
    begin
        ue[0] = n1_side[95:64];
        ue[1] = n1_side[63:32];
        ue[2] = n1_side[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xp_reg[0] <= ue[1] * n1[2];
            xp_reg[1] <= ue[2] * n1[1];
            xp_reg[2] <= ue[2] * n1[0];
            xp_reg[3] <= ue[0] * n1[2];
            xp_reg[4] <= ue[0] * n1[1];
            xp_reg[5] <= ue[1] * n1[0];
            xe_reg[0] <= n1_side[191:160];
            xe_reg[1] <= n1_side[159:128];
            xe_reg[2] <= n1_side[127:96];
            xn_reg    <= n1;
            xok_reg   <= n1_ok;
        end
    end

    // up cross n: differences
    logic signed [63:0] cr_reg [3];
    logic [192:0]       side2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cr_reg[0] <= xp_reg[0] - xp_reg[1];
            cr_reg[1] <= xp_reg[2] - xp_reg[3];
            cr_reg[2] <= xp_reg[4] - xp_reg[5];
            side2_reg <= {xe_reg[0], xe_reg[1], xe_reg[2],
                          xn_reg[0], xn_reg[1], xn_reg[2], xok_reg};
        end
    end

    logic [1:0] xv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xv_reg <= '0;
        end
        else if (en)
        begin
            xv_reg <= {xv_reg[0], n1_valid};
        end
    end

    logic            n2_valid;
    lavm_pkg::word_t u2 [3];
    logic            n2_ok;
    logic [192:0]    n2_side;

    lavm_norm #(
        .IW        (64),
        .SW        (193),
        .FRAC_BITS (FRAC_BITS)
    ) u_norm_u (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (xv_reg[1]),
        .in_c      (cr_reg),
        .in_side   (side2_reg),
        .out_valid (n2_valid),
        .out_n     (u2),
        .out_ok    (n2_ok),
        .out_side  (n2_side)
    );

    // gather the vectors
    mat_t m0;

    always_comb
    begin
        m0    = '0;
        m0.ux = u2[0];
        m0.uy = u2[1];
        m0.uz = u2[2];
        m0.ex = n2_side[192:161];
        m0.ey = n2_side[160:129];
        m0.ez = n2_side[128:97];
        m0.nx = n2_side[96:65];
        m0.ny = n2_side[64:33];
        m0.nz = n2_side[32:1];
        m0.ok = n2_side[0] && n2_ok;
    end

    // stage valid bits after the second normalizer
    logic [7:0] av_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            av_reg <= '0;
        end
        else if (en)
        begin
            av_reg <= {av_reg[6:0], n2_valid};
        end
    end

    // a1: products for n cross u and the u, n dot products
    mat_t               a1_reg;
    logic signed [63:0] pv_reg [6];
    logic signed [63:0] pu_reg [3];
    logic signed [63:0] pn_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg    <= m0;
            pv_reg[0] <= m0.ny * m0.uz;
            pv_reg[1] <= m0.nz * m0.uy;
            pv_reg[2] <= m0.nz * m0.ux;
            pv_reg[3] <= m0.nx * m0.uz;
            pv_reg[4] <= m0.nx * m0.uy;
            pv_reg[5] <= m0.ny * m0.ux;
            pu_reg[0] <= m0.ux * m0.ex;
            pu_reg[1] <= m0.uy * m0.ey;
            pu_reg[2] <= m0.uz * m0.ez;
            pn_reg[0] <= m0.nx * m0.ex;
            pn_reg[1] <= m0.ny * m0.ey;
            pn_reg[2] <= m0.nz * m0.ez;
        end
    end

    // a2: differences and sums
    mat_t               a2_reg;
    logic signed [63:0] vr_reg [3];
    logic signed [63:0] su_reg;
    logic signed [63:0] sn_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a2_reg    <= a1_reg;
            vr_reg[0] <= pv_reg[0] - pv_reg[1];
            vr_reg[1] <= pv_reg[2] - pv_reg[3];
            vr_reg[2] <= pv_reg[4] - pv_reg[5];
            su_reg    <= pu_reg[0] + pu_reg[1] + pu_reg[2];
            sn_reg    <= pn_reg[0] + pn_reg[1] + pn_reg[2];
        end
    end

    // a3: rounding, first half
    mat_t        a3_reg;
    logic [64:0] rm_reg [5];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a3_reg    <= a2_reg;
            rm_reg[0] <= rnd_lo(vr_reg[0], 1'b0);
            rm_reg[1] <= rnd_lo(vr_reg[1], 1'b0);
            rm_reg[2] <= rnd_lo(vr_reg[2], 1'b0);
            rm_reg[3] <= rnd_lo(su_reg, 1'b1);
            rm_reg[4] <= rnd_lo(sn_reg, 1'b1);
        end
    end

    // a4: rounding, second half gives v and two translations
    mat_t a4_next;
    mat_t a4_reg;

    always_comb
    begin
        a4_next    = a3_reg;
        a4_next.vx = rnd_hi(rm_reg[0]);
        a4_next.vy = rnd_hi(rm_reg[1]);
        a4_next.vz = rnd_hi(rm_reg[2]);
        a4_next.tu = rnd_hi(rm_reg[3]);
        a4_next.tn = rnd_hi(rm_reg[4]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a4_reg <= a4_next;
        end
    end

    // a5: v dot eye products
    mat_t               a5_reg;
    logic signed [63:0] pe_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a5_reg    <= a4_reg;
            pe_reg[0] <= a4_reg.vx * a4_reg.ex;
            pe_reg[1] <= a4_reg.vy * a4_reg.ey;
            pe_reg[2] <= a4_reg.vz * a4_reg.ez;
        end
    end

    // a6: sum
    mat_t               a6_reg;
    logic signed [63:0] sv_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a6_reg <= a5_reg;
            sv_reg <= pe_reg[0] + pe_reg[1] + pe_reg[2];
        end
    end

    // a7: rounding, first half
    mat_t        a7_reg;
    logic [64:0] tm_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a7_reg <= a6_reg;
            tm_reg <= rnd_lo(sv_reg, 1'b1);
        end
    end

    // a8: rounding, second half
    mat_t a8_next;
    mat_t a8_reg;

    always_comb
    begin
        a8_next    = a7_reg;
        a8_next.tv = rnd_hi(tm_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a8_reg <= a8_next;
        end
    end

    // output buffer, one group per cycle while out_stall is low
    mat_t           buf_reg;
    logic           bvld_reg;
    lavm_pkg::grp_t grp_reg;

    assign out_take = bvld_reg && !out_stall;
    assign load     = av_reg[7] && (!bvld_reg || (out_take && grp_reg == lavm_pkg::GRP_T));
    assign en       = !av_reg[7] || load;
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bvld_reg <= 1'b0;
            grp_reg  <= lavm_pkg::GRP_X;
        end
        else if (load)
        begin
            bvld_reg <= 1'b1;
            grp_reg  <= lavm_pkg::GRP_X;
        end
        else if (out_take)
        begin
            if (grp_reg == lavm_pkg::GRP_T)
            begin
                bvld_reg <= 1'b0;
                grp_reg  <= lavm_pkg::GRP_X;
            end
            else
            begin
                grp_reg <= grp_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            buf_reg <= a8_reg;
        end
    end

    // group select
    lavm_pkg::word_t wa;
    lavm_pkg::word_t wb;
    lavm_pkg::word_t wc;

    always_comb
    begin
        case (grp_reg)
            lavm_pkg::GRP_X:
            begin
                wa = buf_reg.ux;
                wb = buf_reg.vx;
                wc = buf_reg.nx;
            end
            lavm_pkg::GRP_Y:
            begin
                wa = buf_reg.uy;
                wb = buf_reg.vy;
                wc = buf_reg.ny;
            end
            lavm_pkg::GRP_Z:
            begin
                wa = buf_reg.uz;
                wb = buf_reg.vz;
                wc = buf_reg.nz;
            end
            default:
            begin
                wa = buf_reg.tu;
                wb = buf_reg.tv;
                wc = buf_reg.tn;
            end
        endcase
    end

    assign out_valid   = bvld_reg;
    assign group_index = grp_reg;
    assign word_a      = buf_reg.ok ? wa : '0;
    assign word_b      = buf_reg.ok ? wb : '0;
    assign word_c      = buf_reg.ok ? wc : '0;
    assign word_d      = (grp_reg == lavm_pkg::GRP_T) ? ONE : '0;
    assign last_group  = (grp_reg == lavm_pkg::GRP_T);
    assign degenerate  = !buf_reg.ok;

    // checks
    a_grp_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && grp_reg == lavm_pkg::GRP_T) |=> (grp_reg == lavm_pkg::GRP_X))
        else $error("group counter did not wrap after last group");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (av_reg[7] && bvld_reg))
        else $error("input stalled while pipeline end is free");

    a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (bvld_reg && grp_reg == lavm_pkg::GRP_X))
        else $error("loaded buffer does not start at first group");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && degenerate) |-> (word_a == '0 && word_b == '0 && word_c == '0))
        else $error("degenerate result carries nonzero words");

endmodule
`default_nettype wire

// ===== rtl/lavm_norm.sv =====
`default_nettype none
module lavm_norm #(
    parameter int IW        = 33,
    parameter int SW        = 1,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic signed [IW-1:0] in_c [3],
    input  wire logic [SW-1:0]        in_side,
    output logic                      out_valid,
    output lavm_pkg::word_t           out_n [3],
    output logic                      out_ok,
    output logic [SW-1:0]             out_side
);

    localparam int MW  = IW;
    localparam int PW  = $clog2(MW);
    localparam int NB  = lavm_pkg::NORM_MSB;
    localparam int MBW = NB + 1;
    localparam int QW  = FRAC_BITS + 2;
    localparam int AW  = 31 + QW;
    localparam int SQS = 16;
    localparam int DS  = (QW + 1) / 2;
    localparam int LAT = 23 + DS;
    localparam int CW  = SW + 4;

    // valid bits and sideband (side data, signs, zero flag) along the pipe
    logic [LAT-1:0] vld_reg;
    logic [CW-1:0]  chn_reg [LAT];
    logic [2:0]     sgn_in;
    logic           zero_in;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sgn_in[i] = in_c[i][IW-1];
        end
        zero_in = (in_c[0] == '0) && (in_c[1] == '0) && (in_c[2] == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            chn_reg[0] <= {in_side, sgn_in, zero_in};
            for (int j = 1; j < LAT; j++)
            begin
                chn_reg[j] <= chn_reg[j-1];
            end
        end
    end

    // magnitudes
    logic [MW-1:0] mag_in [3];
    logic [MW-1:0] mag_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_in[i] = in_c[i][IW-1] ? (~unsigned'(in_c[i]) + 1'b1) : unsigned'(in_c[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= mag_in;
        end
    end

    // leading one of the largest magnitude (same as that of the or of all three)
    logic [MW-1:0] orv;
    logic [PW-1:0] pos_next;
    logic [PW-1:0] pos_reg;
    logic [MW-1:0] mag2_reg [3];

    always_comb
    begin
        orv      = mag_reg[0] | mag_reg[1] | mag_reg[2];
        pos_next = '0;
        for (int b = 0; b < MW; b++)
        begin
            if (orv[b])
            begin
                pos_next = PW'(b);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_reg  <= pos_next;
            mag2_reg <= mag_reg;
        end
    end

    // common shift into the normalized window
    logic [MW-1:0]  shr [3];
    logic [MBW-1:0] m3_next [3];
    logic [MBW-1:0] m3_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            shr[i] = mag2_reg[i] >> (pos_reg - PW'(NB));
            if (pos_reg >= PW'(NB))
            begin
                m3_next[i] = shr[i][MBW-1:0];
            end
            else
            begin
                m3_next[i] = mag2_reg[i][MBW-1:0] << (PW'(NB) - pos_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m3_reg <= m3_next;
        end
    end

    // squares
    logic [2*MBW-1:0] sq_reg [3];
    logic [MBW-1:0]   m4_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= m3_reg[i] * m3_reg[i];
            end
            m4_reg <= m3_reg;
        end
    end

    // sum of squares
    logic [63:0]    sum_reg;
    logic [MBW-1:0] m5_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
            m5_reg  <= m4_reg;
        end
    end

    // integer square root, two result bits per stage
    logic [63:0]    sx_reg [SQS];
    logic [63:0]    sr_reg [SQS];
    logic [MBW-1:0] sm_reg [SQS][3];

    for (genvar k = 0; k < SQS; k++)
    begin : g_sqrt
        logic [63:0]    x_in;
        logic [63:0]    r_in;
        logic [MBW-1:0] m_in [3];
        logic [63:0]    x_nx;
        logic [63:0]    r_nx;

        if (k == 0)
        begin : g_first
            assign x_in = sum_reg;
            assign r_in = '0;
            assign m_in = m5_reg;
        end
        else
        begin : g_next
            assign x_in = sx_reg[k-1];
            assign r_in = sr_reg[k-1];
            assign m_in = sm_reg[k-1];
        end

        always_comb
        begin
            logic [63:0] x;
            logic [63:0] r;
            logic [63:0] rb;
            x = x_in;
            r = r_in;
            for (int j = 0; j < 2; j++)
            begin
                rb = r + (64'd1 << (62 - 4*k - 2*j));
                if (x >= rb)
                begin
                    x = x - rb;
                    r = (r >> 1) + (64'd1 << (62 - 4*k - 2*j));
                end
                else
                begin
                    r = r >> 1;
                end
            end
            x_nx = x;
            r_nx = r;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sx_reg[k] <= x_nx;
                sr_reg[k] <= r_nx;
                sm_reg[k] <= m_in;
            end
        end
    end

    // division setup: rounded numerator and divisor
    logic [30:0]   len;
    logic [AW-1:0] acc_reg [3];
    logic [30:0]   len_reg;

    assign len = sr_reg[SQS-1][30:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                acc_reg[i] <= (AW'(sm_reg[SQS-1][i]) << FRAC_BITS) + AW'(len >> 1);
            end
            len_reg <= len;
        end
    end

    // restoring division, two quotient bits per stage
    logic [AW-1:0] da_reg [DS][3];
    logic [30:0]   dl_reg [DS];

    for (genvar k = 0; k < DS; k++)
    begin : g_div
        logic [AW-1:0] a_in [3];
        logic [30:0]   l_in;
        logic [AW-1:0] a_nx [3];

        if (k == 0)
        begin : g_first
            assign a_in = acc_reg;
            assign l_in = len_reg;
        end
        else
        begin : g_next
            assign a_in = da_reg[k-1];
            assign l_in = dl_reg[k-1];
        end

        always_comb
        begin
            logic [AW-1:0] a;
            logic [31:0]   t;
            for (int i = 0; i < 3; i++)
            begin
                a = a_in[i];
                for (int j = 0; j < 2; j++)
                begin
                    if (2*k + j < QW)
                    begin
                        t = a[AW-1:QW-1];
                        if (t >= {1'b0, l_in})
                        begin
                            t = t - {1'b0, l_in};
                            a = {t[30:0], a[QW-2:0], 1'b1};
                        end
                        else
                        begin
                            a = {t[30:0], a[QW-2:0], 1'b0};
                        end
                    end
                end
                a_nx[i] = a;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                da_reg[k] <= a_nx;
                dl_reg[k] <= l_in;
            end
        end
    end

    // sign restore, saturation and zero vector
    logic [CW-1:0]   chn_fin;
    logic [32:0]     qq [3];
    lavm_pkg::word_t n_next [3];
    lavm_pkg::word_t n_reg [3];

    assign chn_fin = chn_reg[LAT-2];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qq[i] = 33'(da_reg[DS-1][i][QW-1:0]);
            if (chn_fin[0])
            begin
                n_next[i] = '0;
            end
            else if (!chn_fin[i+1])
            begin
                n_next[i] = (qq[i] > 33'h0_7FFF_FFFF) ? lavm_pkg::WORD_MAX
                                                      : lavm_pkg::word_t'(qq[i][31:0]);
            end
            else
            begin
                n_next[i] = (qq[i] > 33'h0_8000_0000) ? lavm_pkg::WORD_MIN
                                                      : lavm_pkg::word_t'(~qq[i][31:0] + 32'd1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg <= n_next;
        end
    end

    assign out_valid = vld_reg[LAT-1];
    assign out_n     = n_reg;
    assign out_ok    = !chn_reg[LAT-1][0];
    assign out_side  = chn_reg[LAT-1][CW-1:4];

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 16;
    localparam int IDLE_LIMIT = 4000;
    localparam int N_RANDOM = 300;

    typedef struct {
        lavm_pkg::word_t ex, ey, ez, tx, ty, tz, ux, uy, uz;
        bit              hold_until_drained;
    } view_req_t;

    typedef struct {
        lavm_pkg::grp_t  grp;
        lavm_pkg::word_t a, b, c, d;
        logic            last, degen;
    } matrix_group_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_stall;
    lavm_pkg::word_t eye_x = '0, eye_y = '0, eye_z = '0;
    lavm_pkg::word_t target_x = '0, target_y = '0, target_z = '0;
    lavm_pkg::word_t up_x = '0, up_y = '0, up_z = '0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    lavm_pkg::grp_t  group_index;
    lavm_pkg::word_t word_a, word_b, word_c, word_d;
    logic            last_group, degenerate;

    view_req_t     pending_q[$];
    matrix_group_t matrix_q[$];
    view_req_t     cur_req;
    int            n_errors = 0;
    int            n_sent = 0;
    int            n_groups = 0;
    int            n_degen = 0;
    int            idle_cycles = 0;
    int            in_gap = 0;
    int            out_gap = 0;
    bit            calm = 1'b0;

    look_at_view_matrix dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .eye_x(eye_x), .eye_y(eye_y), .eye_z(eye_z),
        .target_x(target_x), .target_y(target_y), .target_z(target_z),
        .up_x(up_x), .up_y(up_y), .up_z(up_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .group_index(group_index),
        .word_a(word_a), .word_b(word_b), .word_c(word_c), .word_d(word_d),
        .last_group(last_group), .degenerate(degenerate)
    );

    always #4 clk = ~clk;

    // fixed-point helpers
    function automatic longint unsigned abs64(longint x);
        return x < 0 ? longint'(0) - x : x;
    endfunction

    function automatic longint sat32(longint x);
        if (x > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
        if (x < -64'sh8000_0000) return -64'sh8000_0000;
        return x;
    endfunction

    function automatic longint round_frac(longint x);
        longint unsigned m;
        m = (abs64(x) + (64'd1 << (FB - 1))) >> FB;
        return x < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned sqrt_floor(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // unit vector in fixed point, returns 0 for a zero vector
    function automatic bit unit_vec(input longint c0, c1, c2,
                                    output longint o0, o1, o2);
        longint unsigned m[3];
        longint          c[3];
        longint          o[3];
        longint unsigned big, len, q;
        c[0] = c0; c[1] = c1; c[2] = c2;
        for (int i = 0; i < 3; i++) m[i] = abs64(c[i]);
        big = m[0];
        if (m[1] > big) big = m[1];
        if (m[2] > big) big = m[2];
        o0 = 0; o1 = 0; o2 = 0;
        if (big == 0) return 1'b0;
        while (big >= (64'd1 << 30)) begin
            big >>= 1;
            for (int i = 0; i < 3; i++) m[i] >>= 1;
        end
        while (big < (64'd1 << 29)) begin
            big <<= 1;
            for (int i = 0; i < 3; i++) m[i] <<= 1;
        end
        len = sqrt_floor(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << FB) + (len >> 1)) / len;
            o[i] = sat32(c[i] < 0 ? -longint'(q) : longint'(q));
        end
        o0 = o[0]; o1 = o[1]; o2 = o[2];
        return 1'b1;
    endfunction

    // builds the four expected matrix groups of one request
    function automatic void predict_view(view_req_t r);
        longint e[3], up[3], n[3], u[3], v[3], tr[3], w[16];
        bit ok;
        matrix_group_t g;
        e[0] = r.ex; e[1] = r.ey; e[2] = r.ez;
        up[0] = r.ux; up[1] = r.uy; up[2] = r.uz;
        ok = unit_vec(e[0] - longint'(r.tx), e[1] - longint'(r.ty),
                      e[2] - longint'(r.tz), n[0], n[1], n[2]);
        if (!unit_vec(up[1] * n[2] - up[2] * n[1], up[2] * n[0] - up[0] * n[2],
                      up[0] * n[1] - up[1] * n[0], u[0], u[1], u[2]))
            ok = 1'b0;
        v[0] = sat32(round_frac(n[1] * u[2] - n[2] * u[1]));
        v[1] = sat32(round_frac(n[2] * u[0] - n[0] * u[2]));
        v[2] = sat32(round_frac(n[0] * u[1] - n[1] * u[0]));
        tr[0] = sat32(round_frac(-(u[0] * e[0] + u[1] * e[1] + u[2] * e[2])));
        tr[1] = sat32(round_frac(-(v[0] * e[0] + v[1] * e[1] + v[2] * e[2])));
        tr[2] = sat32(round_frac(-(n[0] * e[0] + n[1] * e[1] + n[2] * e[2])));
        for (int i = 0; i < 3; i++) begin
            w[4 * i] = u[i];
            w[4 * i + 1] = v[i];
            w[4 * i + 2] = n[i];
            w[4 * i + 3] = 0;
        end
        w[12] = tr[0]; w[13] = tr[1]; w[14] = tr[2];
        w[15] = longint'(1) << FB;
        // zero-length direction or cross product blanks all but the fourth word of each group
        if (!ok)
            for (int i = 0; i < 16; i++) if ((i & 3) != 3) w[i] = 0;
        if (!ok) n_degen++;
        for (int k = 0; k < 4; k++) begin
            g.grp = lavm_pkg::grp_t'(k);
            g.a = w[4 * k][31:0];
            g.b = w[4 * k + 1][31:0];
            g.c = w[4 * k + 2][31:0];
            g.d = w[4 * k + 3][31:0];
            g.last = (g.grp == lavm_pkg::GRP_T);
            g.degen = !ok;
            matrix_q.push_back(g);
        end
    endfunction

    // gap length: mostly short, sometimes long
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            n_errors++;
        end
    endtask

    // driver: requests from the pending queue
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                predict_view(cur_req);
                n_sent++;
            end
            if (in_valid && in_stall) begin
                // hold the stalled request
            end else if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end else if (pending_q.size() == 0) begin
                in_valid <= 1'b0;
            end else if (pending_q[0].hold_until_drained &&
                         (matrix_q.size() != 0 || (in_valid && !in_stall))) begin
                in_valid <= 1'b0;
            end else begin
                cur_req = pending_q.pop_front();
                eye_x <= cur_req.ex; eye_y <= cur_req.ey; eye_z <= cur_req.ez;
                target_x <= cur_req.tx; target_y <= cur_req.ty; target_z <= cur_req.tz;
                up_x <= cur_req.ux; up_y <= cur_req.uy; up_z <= cur_req.uz;
                in_valid <= 1'b1;
                in_gap <= calm ? 0 : pick_gap();
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge clk or negedge rst_n) begin
        matrix_group_t g;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                n_groups++;
                if (matrix_q.size() == 0) begin
                    $error("unexpected group %0d", group_index);
                    n_errors++;
                end else begin
                    g = matrix_q.pop_front();
                    check_field("group_index", g.grp, group_index);
                    check_field("word_a", g.a, word_a);
                    check_field("word_b", g.b, word_b);
                    check_field("word_c", g.c, word_c);
                    check_field("word_d", g.d, word_d);
                    check_field("last_group", g.last, last_group);
                    check_field("degenerate", g.degen, degenerate);
                end
            end
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                out_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                out_gap <= pick_gap();
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog and stretches without idling
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if ($urandom_range(0, 199) == 0) calm <= ~calm;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL look_at_view_matrix");
            $finish;
        end
    end

    function automatic view_req_t make_view(longint ex, ey, ez, tx, ty, tz,
                                            ux, uy, uz, bit hold);
        view_req_t r;
        r.ex = ex[31:0]; r.ey = ey[31:0]; r.ez = ez[31:0];
        r.tx = tx[31:0]; r.ty = ty[31:0]; r.tz = tz[31:0];
        r.ux = ux[31:0]; r.uy = uy[31:0]; r.uz = uz[31:0];
        r.hold_until_drained = hold;
        return r;
    endfunction

    function automatic longint rand_scaled(int mode);
        case (mode)
            0: return longint'($signed($urandom()));
            1: return longint'($urandom_range(0, 200 << FB)) - (100 << FB);
            default: return longint'($urandom_range(0, 8)) - 4;
        endcase
    endfunction

    initial begin
        longint mx, mn, one;
        view_req_t r;
        int mode, kind;
        mx = 64'sh7FFF_FFFF;
        mn = -64'sh8000_0000;
        one = longint'(1) << FB;

        // directed requests
        pending_q.push_back(make_view(0, 0, 5 * one, 0, 0, 0, 0, one, 0, 0));
        pending_q.push_back(make_view(mx, mx, mx, mn, mn, mn, mx, mn, mx, 0));
        pending_q.push_back(make_view(mn, mn, mn, mx, mx, mx, mn, mx, mn, 0));
        pending_q.push_back(make_view(mx, 0, 0, mn, 0, 0, 0, mx, 0, 0));
        pending_q.push_back(make_view(mn, mx, 0, mx, mn, 0, 0, 0, mn, 0));
        // eye on target
        pending_q.push_back(make_view(3 * one, -one, 7, 3 * one, -one, 7, 0, one, 0, 0));
        // up parallel to view direction
        pending_q.push_back(make_view(0, 9 * one, 0, 0, 0, 0, 0, one, 0, 0));
        // zero up vector
        pending_q.push_back(make_view(one, 2 * one, 3 * one, 0, 0, 0, 0, 0, 0, 0));
        // both zero, drained first
        pending_q.push_back(make_view(0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        // one-lsb direction and tiny up
        pending_q.push_back(make_view(1, 0, 0, 0, 0, 0, 0, 1, 0, 0));
        pending_q.push_back(make_view(-1, -1, -1, 0, 0, 0, 1, -1, 1, 0));
        pending_q.push_back(make_view(mx, mx, mx, 0, 0, 0, -one, one, 0, 0));
        pending_q.push_back(make_view(mn, mn, mn, mx, 0, 0, mx, mx, mx, 0));
        pending_q.push_back(make_view(12345, -67890, one, -one, 3, 99, 5, -one, 77, 0));
        pending_q.push_back(make_view(mx, mn, mx, mn, mx, mn, mn, mn, mn, 0));

        // random requests
        for (int i = 0; i < N_RANDOM; i++) begin
            mode = $urandom_range(0, 9) < 4 ? 0 : ($urandom_range(0, 9) < 8 ? 1 : 2);
            r = make_view(rand_scaled(mode), rand_scaled(mode), rand_scaled(mode),
                          rand_scaled(mode), rand_scaled(mode), rand_scaled(mode),
                          rand_scaled(mode), rand_scaled(mode), rand_scaled(mode),
                          i == N_RANDOM / 2);
            kind = $urandom_range(0, 19);
            if (kind == 0) begin
                r.tx = r.ex; r.ty = r.ey; r.tz = r.ez;
            end else if (kind == 1) begin
                r.ty = r.ey; r.tz = r.ez; r.uy = 0; r.uz = 0;
            end
            pending_q.push_back(r);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_q.size() == 0 && !in_valid && matrix_q.size() == 0);
        repeat (120) @(posedge clk);
        if (matrix_q.size() != 0) begin
            $error("%0d groups never arrived", matrix_q.size());
            n_errors++;
        end
        $display("covered %0d view requests (%0d degenerate), %0d matrix groups checked",
                 n_sent, n_degen, n_groups);
        if (n_errors == 0)
            $display("PASS look_at_view_matrix");
        else
            $display("FAIL look_at_view_matrix");
        $finish;
    end
endmodule
`default_nettype wire

// ===== look_at_view_matrix.f =====
rtl/lavm_pkg.sv
rtl/lavm_norm.sv
rtl/look_at_view_matrix.sv
verif/tb_top.sv
